FILE: src/arer_pkg.sv
// Shared constants and types of the attack/release envelope unit.
package arer_pkg;

   localparam int LEN_BITS_DEF   = 24;
   localparam int LEVEL_BITS_DEF = 16;
   localparam int CSR_ADDR_W     = 5;
   localparam int CSR_DATA_W     = 32;
   localparam int REQ_DATA_W     = 8;

   typedef enum logic [2:0] {
      REG_ATTACK_START  = 3'd0,
      REG_ATTACK_END    = 3'd1,
      REG_ATTACK_LEN    = 3'd2,
      REG_RELEASE_START = 3'd3,
      REG_RELEASE_END   = 3'd4,
      REG_RELEASE_LEN   = 3'd5
   } reg_idx_type;

   typedef enum logic {
      OP_TICK    = 1'b0,
      OP_RESTART = 1'b1
   } op_type;

endpackage

FILE: src/attack_release_envelope_unit.sv
// Top level of the attack/release envelope unit: registers, ramp counters and sequencing.
//
//   channel  direction  transfer carries
//   req      in         tuser: op; tdata: release_on in bit 0
//   rsp      out        tdata: level (low bits), done_res above it
//   csr      in/out     APB register file, six registers at 4-byte spacing
//
// A restart transfer reloads both ramp counters and gives no response. A tick runs both
// ramps and, with release, then the multiplier before its result is loaded into rsp.
// Both ramps run their bit-serial divide-and-scale in parallel, one quotient
// bit per cycle; the release product is then formed one multiplier bit per cycle.
// Reset clears the registers, both ramp counters and the state and valid flags, but not rel_on.
// A finished result waits in the rsp register; a stalled rsp holds only the final step.
module attack_release_envelope_unit
   import arer_pkg::*;
#(
   parameter int LEN_BITS   = LEN_BITS_DEF,
   parameter int LEVEL_BITS = LEVEL_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [REQ_DATA_W-1:0]        req_tdata,   // [0] release_on
   input  logic                         req_tuser,   // [0] op
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [((LEVEL_BITS+8)/8)*8-1:0] rsp_tdata, // level, then done_res
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]        csr_paddr,
   input  logic [CSR_DATA_W-1:0]        csr_pwdata,
   output logic [CSR_DATA_W-1:0]        csr_prdata,
   output logic                         csr_pready
);

   localparam int RSP_W = ((LEVEL_BITS + 8) / 8) * 8;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_RAMP = 4'b0010,
      ST_MUL  = 4'b0100,
      ST_FIN  = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   logic signed [LEVEL_BITS-1:0] atk_start_ff, atk_end_ff, rel_start_ff, rel_end_ff;
   logic [LEN_BITS-1:0]          atk_len_ff, rel_len_ff;
   logic [LEN_BITS-1:0]          atk_rem_ff, atk_rem_in;
   logic [LEN_BITS-1:0]          rel_rem_ff, rel_rem_in;
   logic                         rel_on_ff, rel_on_in;
   logic                         empty_ff, empty_in;
   logic signed [LEVEL_BITS-1:0] level_ff, level_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic signed [LEVEL_BITS-1:0] rsp_level_ff, rsp_level_in;
   logic                         rsp_done_ff, rsp_done_in;

   logic                         csr_wr;
   reg_idx_type                  csr_idx;
   logic                         req_xfer, tick, restart;
   logic                         rsp_load, mul_go;
   logic                         atk_done, rel_done, mul_done;
   logic signed [LEVEL_BITS-1:0] atk_value, rel_value, mul_value;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_idx    = reg_idx_type'(csr_paddr[4:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         atk_start_ff <= '0;
         atk_end_ff   <= '0;
         atk_len_ff   <= '0;
         rel_start_ff <= '0;
         rel_end_ff   <= '0;
         rel_len_ff   <= '0;
      end else if (csr_wr) begin
         unique case (csr_idx)
            REG_ATTACK_START:  atk_start_ff <= csr_pwdata[LEVEL_BITS-1:0];
            REG_ATTACK_END:    atk_end_ff   <= csr_pwdata[LEVEL_BITS-1:0];
            REG_ATTACK_LEN:    atk_len_ff   <= csr_pwdata[LEN_BITS-1:0];
            REG_RELEASE_START: rel_start_ff <= csr_pwdata[LEVEL_BITS-1:0];
            REG_RELEASE_END:   rel_end_ff   <= csr_pwdata[LEVEL_BITS-1:0];
            REG_RELEASE_LEN:   rel_len_ff   <= csr_pwdata[LEN_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         REG_ATTACK_START:  csr_prdata = CSR_DATA_W'($unsigned(atk_start_ff));
         REG_ATTACK_END:    csr_prdata = CSR_DATA_W'($unsigned(atk_end_ff));
         REG_ATTACK_LEN:    csr_prdata = CSR_DATA_W'(atk_len_ff);
         REG_RELEASE_START: csr_prdata = CSR_DATA_W'($unsigned(rel_start_ff));
         REG_RELEASE_END:   csr_prdata = CSR_DATA_W'($unsigned(rel_end_ff));
         REG_RELEASE_LEN:   csr_prdata = CSR_DATA_W'(rel_len_ff);
         default:           csr_prdata = '0;
      endcase
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign req_xfer   = req_tvalid && req_tready;
   assign tick       = req_xfer && (op_type'(req_tuser) == OP_TICK);
   assign restart    = req_xfer && (op_type'(req_tuser) == OP_RESTART);

   arer_ramp #(.LEN_BITS(LEN_BITS), .LEVEL_BITS(LEVEL_BITS)) u_atk_ramp (
      .clock       (clock),
      .reset       (reset),
      .go          (tick),
      .start_level (atk_start_ff),
      .end_level   (atk_end_ff),
      .len         (atk_len_ff),
      .rem         (atk_rem_ff),
      .done        (atk_done),
      .value       (atk_value)
   );

   arer_ramp #(.LEN_BITS(LEN_BITS), .LEVEL_BITS(LEVEL_BITS)) u_rel_ramp (
      .clock       (clock),
      .reset       (reset),
      .go          (tick),
      .start_level (rel_start_ff),
      .end_level   (rel_end_ff),
      .len         (rel_len_ff),
      .rem         (rel_rem_ff),
      .done        (rel_done),
      .value       (rel_value)
   );

   arer_smul #(.LEVEL_BITS(LEVEL_BITS)) u_smul (
      .clock   (clock),
      .reset   (reset),
      .go      (mul_go),
      .a       (atk_value),
      .b       (rel_value),
      .done    (mul_done),
      .product (mul_value)
   );

   always_comb begin
      atk_rem_in = atk_rem_ff;
      rel_rem_in = rel_rem_ff;
      rel_on_in  = rel_on_ff;
      empty_in   = empty_ff;
      if (restart) begin
         atk_rem_in = atk_len_ff;
         rel_rem_in = rel_len_ff;
      end else if (tick) begin
         rel_on_in = req_tdata[0];
         empty_in  = req_tdata[0] && (rel_rem_ff == '0);
         if (atk_rem_ff != '0) begin
            atk_rem_in = atk_rem_ff - LEN_BITS'(1);
         end
         if (req_tdata[0] && (rel_rem_ff != '0)) begin
            rel_rem_in = rel_rem_ff - LEN_BITS'(1);
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      level_in = level_ff;
      mul_go   = 1'b0;
      rsp_load = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (tick) begin
               state_in = ST_RAMP;
            end
         end
         ST_RAMP: begin
            if (atk_done && rel_done) begin
               if (rel_on_ff) begin
                  mul_go   = 1'b1;
                  state_in = ST_MUL;
               end else begin
                  level_in = atk_value;
                  state_in = ST_FIN;
               end
            end
         end
         ST_MUL: begin
            if (mul_done) begin
               level_in = mul_value;
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_level_in = rsp_level_ff;
      rsp_done_in  = rsp_done_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_level_in = level_ff;
         rsp_done_in  = empty_ff;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         atk_rem_ff   <= '0;
         rel_rem_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         atk_rem_ff   <= atk_rem_in;
         rel_rem_ff   <= rel_rem_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rel_on_ff    <= rel_on_in;
      empty_ff     <= empty_in;
      level_ff     <= level_in;
      rsp_level_ff <= rsp_level_in;
      rsp_done_ff  <= rsp_done_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_W'({rsp_done_ff, rsp_level_ff});

   a_ramp_done_in_ramp : assert property (@(posedge clock) disable iff (reset)
      atk_done |-> (state_ff == ST_RAMP))
      else $error("attack ramp finished outside the ramp state");

   a_mul_done_in_mul : assert property (@(posedge clock) disable iff (reset)
      mul_done |-> (state_ff == ST_MUL))
      else $error("multiplier finished outside the multiply state");

   a_restart_reload : assert property (@(posedge clock) disable iff (reset)
      (!reset && restart) |=> (atk_rem_ff == $past(atk_len_ff))
         && (rel_rem_ff == $past(rel_len_ff)))
      else $error("restart did not reload the ramp counters");

   a_attack_count : assert property (@(posedge clock) disable iff (reset)
      (!reset && tick && (atk_rem_ff != '0))
         |=> (atk_rem_ff == $past(atk_rem_ff) - LEN_BITS'(1)))
      else $error("attack counter did not step on a tick");

endmodule

FILE: src/arer_ramp.sv
// Bit-serial ramp evaluator: restoring fraction divider fused with a shift-add scaler.
module arer_ramp
   import arer_pkg::*;
#(
   parameter int LEN_BITS   = LEN_BITS_DEF,
   parameter int LEVEL_BITS = LEVEL_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         go,
   input  logic signed [LEVEL_BITS-1:0] start_level,
   input  logic signed [LEVEL_BITS-1:0] end_level,
   input  logic        [LEN_BITS-1:0]   len,
   input  logic        [LEN_BITS-1:0]   rem,
   output logic                         done,
   output logic signed [LEVEL_BITS-1:0] value
);

   localparam int FRAC  = LEVEL_BITS - 1;
   localparam int ACC_W = 2 * LEVEL_BITS + 1;
   localparam int CNT_W = $clog2(LEVEL_BITS);
   localparam logic [CNT_W-1:0] LAST = CNT_W'(LEVEL_BITS - 1);

   logic                         run_ff, run_in;
   logic                         done_ff, done_in;
   logic [CNT_W-1:0]             cnt_ff, cnt_in;
   logic                         zl_ff, zl_in;
   logic [LEN_BITS-1:0]          len_ff, len_in;
   logic [LEN_BITS:0]            part_ff, part_in;
   logic signed [LEVEL_BITS:0]   diff_ff, diff_in;
   logic signed [LEVEL_BITS-1:0] end_ff, end_in;
   logic signed [ACC_W-1:0]      acc_ff, acc_in;

   logic [LEN_BITS:0]            trial;
   logic                         take;
   logic signed [ACC_W-1:0]      diff_ext;
   logic signed [ACC_W-1:0]      acc_sh;

   always_comb begin
      trial    = (cnt_ff == '0) ? part_ff : {part_ff[LEN_BITS-1:0], 1'b0};
      take     = !zl_ff && (trial >= {1'b0, len_ff});
      diff_ext = ACC_W'(diff_ff);

      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      zl_in   = zl_ff;
      len_in  = len_ff;
      part_in = part_ff;
      diff_in = diff_ff;
      end_in  = end_ff;
      acc_in  = acc_ff;

      if (go) begin
         run_in  = 1'b1;
         cnt_in  = '0;
         zl_in   = (len == '0);
         len_in  = len;
         part_in = {1'b0, (rem > len) ? len : rem};
         diff_in = (LEVEL_BITS + 1)'(start_level) - (LEVEL_BITS + 1)'(end_level);
         end_in  = end_level;
         acc_in  = '0;
      end else if (run_ff) begin
         part_in = take ? (trial - {1'b0, len_ff}) : trial;
         acc_in  = (acc_ff <<< 1) + (take ? diff_ext : '0);
         cnt_in  = cnt_ff + CNT_W'(1);
         if (cnt_ff == LAST) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      zl_ff   <= zl_in;
      len_ff  <= len_in;
      part_ff <= part_in;
      diff_ff <= diff_in;
      end_ff  <= end_in;
      acc_ff  <= acc_in;
   end

   assign acc_sh = acc_ff >>> FRAC;
   assign done   = done_ff;
   assign value  = end_ff + acc_sh[LEVEL_BITS-1:0];

endmodule

FILE: src/arer_smul.sv
// Bit-serial signed fixed-point multiplier with a saturating result.
module arer_smul
   import arer_pkg::*;
#(
   parameter int LEVEL_BITS = LEVEL_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         go,
   input  logic signed [LEVEL_BITS-1:0] a,
   input  logic signed [LEVEL_BITS-1:0] b,
   output logic                         done,
   output logic signed [LEVEL_BITS-1:0] product
);

   localparam int FRAC  = LEVEL_BITS - 1;
   localparam int ACC_W = 2 * LEVEL_BITS;
   localparam int CNT_W = $clog2(LEVEL_BITS);
   localparam logic [CNT_W-1:0] LAST = CNT_W'(LEVEL_BITS - 1);
   localparam logic signed [ACC_W-1:0] P_MAX = ACC_W'((2 ** (LEVEL_BITS - 1)) - 1);
   localparam logic signed [ACC_W-1:0] P_MIN = -ACC_W'(2 ** (LEVEL_BITS - 1));

   logic                         run_ff, run_in;
   logic                         done_ff, done_in;
   logic [CNT_W-1:0]             cnt_ff, cnt_in;
   logic signed [LEVEL_BITS-1:0] a_ff, a_in;
   logic [LEVEL_BITS-1:0]        b_ff, b_in;
   logic signed [ACC_W-1:0]      acc_ff, acc_in;

   logic signed [ACC_W-1:0]      a_ext;
   logic signed [ACC_W-1:0]      term;
   logic signed [ACC_W-1:0]      acc_sh;

   always_comb begin
      a_ext = ACC_W'(a_ff);
      if (!b_ff[LEVEL_BITS-1]) begin
         term = '0;
      end else if (cnt_ff == '0) begin
         term = -a_ext;
      end else begin
         term = a_ext;
      end

      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      acc_in  = acc_ff;

      if (go) begin
         run_in = 1'b1;
         cnt_in = '0;
         a_in   = a;
         b_in   = b;
         acc_in = '0;
      end else if (run_ff) begin
         acc_in = (acc_ff <<< 1) + term;
         b_in   = {b_ff[LEVEL_BITS-2:0], 1'b0};
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == LAST) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff   <= a_in;
      b_ff   <= b_in;
      acc_ff <= acc_in;
   end

   always_comb begin
      acc_sh = acc_ff >>> FRAC;
      if (acc_sh > P_MAX) begin
         product = P_MAX[LEVEL_BITS-1:0];
      end else if (acc_sh < P_MIN) begin
         product = P_MIN[LEVEL_BITS-1:0];
      end else begin
         product = acc_sh[LEVEL_BITS-1:0];
      end
   end

   assign done = done_ff;

endmodule
